### hw/rtl/sem_pkg.sv
`default_nettype none
package sem_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int CFG_W          = 11;
    localparam int PIX_W          = 24;
    localparam int ROOT_W         = 8;
    localparam int SQ_LIMIT       = 65280;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] edge_red;
        logic [7:0] edge_green;
        logic [7:0] edge_blue;
        logic       frame_end;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_SQUARE,
        ST_ROOT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic advance;
        logic calc;
        logic square;
        logic root_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic drop;
        logic emit;
        logic root_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

### hw/rtl/sem_ram.sv
`default_nettype none
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/sem_ctrl.sv
`default_nettype none
module sem_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pixel_valid,
    output logic                  pixel_ready,
    input  wire sem_pkg::status_t status,
    output sem_pkg::cmd_t         cmd,
    output sem_pkg::state_t       state
);
    import sem_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        pixel_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid && !status.drop)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.advance = 1'b1;
                state_next  = status.emit ? ST_CALC : ST_IDLE;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;
endmodule
`default_nettype wire

### hw/rtl/sem_datapath.sv
`default_nettype none
module sem_datapath #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic                     cfg_index,
    input  wire logic [sem_pkg::CFG_W-1:0] cfg_data,
    input  wire sem_pkg::pixel_t          pixel,
    input  wire logic                     result_ready,
    output logic                          result_valid,
    output sem_pkg::result_t              result,
    input  wire sem_pkg::cmd_t            cmd,
    output sem_pkg::status_t              status
);
    import sem_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 2);

    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;

    logic [AW-1:0] in_col_reg, out_col_reg;
    logic [HW-1:0] in_row_reg, out_row_reg;
    logic          filling;

    logic [PIX_W-1:0] fresh_reg;
    logic [PIX_W-1:0] upper_q, middle_q;
    logic [PIX_W-1:0] win_reg [3][3];

    logic [9:0]  ax_reg [3];
    logic [9:0]  ay_reg [3];
    logic [20:0] sum_reg [3];
    logic [ROOT_W-1:0] root_reg [3];
    logic [2:0]  bit_reg;

    logic    result_valid_reg;
    result_t result_reg;

    logic col_wrap, out_col_wrap, last;

    // Configuration registers and the clamped frame size.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_W'(1024);
            frame_height_reg <= CFG_W'(1024);
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data;
            end
            else
            begin
                frame_height_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = WW'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(frame_width_reg);
        if (frame_height_reg == '0)
            h_eff = HW'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(frame_height_reg);
    end

    assign filling      = in_row_reg < h_eff;
    assign col_wrap     = ((WW + 1)'(in_col_reg) + 1'b1) >= (WW + 1)'(w_eff);
    assign out_col_wrap = ((WW + 1)'(out_col_reg) + 1'b1) >= (WW + 1)'(w_eff);
    assign last = (((HW + 1)'(out_row_reg) + 1'b1) >= (HW + 1)'(h_eff)) && out_col_wrap;

    assign status.drop      = filling && (pixel.action == ACT_FLUSH);
    assign status.emit      = (in_row_reg >= HW'(2)) ||
                              ((in_row_reg == HW'(1)) && (in_col_reg != '0));
    assign status.root_last = (bit_reg == 3'd0);
    assign status.out_free  = !result_valid_reg || result_ready;

    // Position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (cfg_write || (cmd.finish && last))
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            if (cmd.advance)
            begin
                if (col_wrap)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                if (out_col_wrap)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            fresh_reg <= filling ? {pixel.red, pixel.green, pixel.blue} : '0;
        end
    end

    // The read is issued while idle, so the data is ready in the next state.
    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (cmd.advance),
        .waddr (in_col_reg),
        .wdata (middle_q),
        .raddr (in_col_reg),
        .rdata (upper_q)
    );

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (cmd.advance),
        .waddr (in_col_reg),
        .wdata (fresh_reg),
        .raddr (in_col_reg),
        .rdata (middle_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else if (cmd.advance)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= upper_q;
            win_reg[1][2] <= middle_q;
            win_reg[2][2] <= fresh_reg;
        end
    end

    // Masked Sobel sums per channel.
    logic row_ok0, row_ok2, col_ok0, col_ok2;
    logic signed [11:0] v [3][3];
    logic signed [11:0] gx [3];
    logic signed [11:0] gy [3];

    assign row_ok0 = out_row_reg != '0;
    assign row_ok2 = ((HW + 1)'(out_row_reg) + 1'b1) < (HW + 1)'(h_eff);
    assign col_ok0 = out_col_reg != '0;
    assign col_ok2 = !out_col_wrap;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (((r == 0) && !row_ok0) || ((r == 2) && !row_ok2) ||
                        ((c == 0) && !col_ok0) || ((c == 2) && !col_ok2))
                        v[r][c] = '0;
                    else
                        v[r][c] = $signed({4'd0, win_reg[r][c][(23 - 8 * ch) -: 8]});
                end
            end
            gx[ch] = v[0][2] - v[0][0] + 12'sd2 * (v[1][2] - v[1][0]) + v[2][2] - v[2][0];
            gy[ch] = v[2][0] - v[0][0] + 12'sd2 * (v[2][1] - v[0][1]) + v[2][2] - v[0][2];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (cmd.calc)
            begin
                ax_reg[ch] <= gx[ch][11] ? 10'(-gx[ch]) : gx[ch][9:0];
                ay_reg[ch] <= gy[ch][11] ? 10'(-gy[ch]) : gy[ch][9:0];
            end
            if (cmd.square)
            begin
                sum_reg[ch]  <= 21'(ax_reg[ch] * ax_reg[ch]) + 21'(ay_reg[ch] * ay_reg[ch]);
                root_reg[ch] <= '0;
            end
            else if (cmd.root_step)
            begin
                if (16'((root_reg[ch] | (ROOT_W'(1) << bit_reg)) *
                        (root_reg[ch] | (ROOT_W'(1) << bit_reg))) <= sum_reg[ch][15:0])
                    root_reg[ch] <= root_reg[ch] | (ROOT_W'(1) << bit_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_reg <= 3'd7;
        else if (cmd.square)
            bit_reg <= 3'd7;
        else if (cmd.root_step)
            bit_reg <= bit_reg - 1'b1;
    end

    // Rounding and saturation of the floor root.
    logic [ROOT_W-1:0] mag [3];
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (sum_reg[ch] > 21'(SQ_LIMIT))
                mag[ch] = 8'hFF;
            else if (17'(sum_reg[ch][15:0]) >
                     17'(root_reg[ch] * root_reg[ch]) + 17'(root_reg[ch]))
                mag[ch] = root_reg[ch] + 1'b1;
            else
                mag[ch] = root_reg[ch];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.finish)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.edge_red   <= mag[0];
            result_reg.edge_green <= mag[1];
            result_reg.edge_blue  <= mag[2];
            result_reg.frame_end  <= last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
endmodule
`default_nettype wire

### hw/rtl/sobel_edge_magnitude_rgb_unit.sv
`default_nettype none
// Channel   Direction  Handshake                   Word
// pixel     in         pixel_valid / pixel_ready   sem_pkg::pixel_t
// result    out        result_valid / result_ready sem_pkg::result_t
// config    in         cfg_write (no wait)         cfg_index, cfg_data
//
// A pixel that yields a result passes through these steps: accept and read the
// line buffers, update them and the window, form the Sobel sums, form the
// squares, run the bit-serial root, then load the output register once it is
// free. A pixel with no result only accepts and updates, and a flush that
// arrives while the frame is still coming in is taken and dropped while idle.
// Reset clears the controller, the counters, the window and the valid flag;
// the line buffers are not cleared, since reads outside the frame are masked.
// A stalled result waits in the output register while the next word is taken.
module sobel_edge_magnitude_rgb_unit #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic                      cfg_index,
    input  wire logic [sem_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      pixel_valid,
    output logic                           pixel_ready,
    input  wire sem_pkg::pixel_t           pixel,
    output logic                           result_valid,
    input  wire logic                      result_ready,
    output sem_pkg::result_t               result
);
    import sem_pkg::*;

    cmd_t    cmd;
    status_t status;
    state_t  state;

    // The controller sequences one word at a time through the datapath.
    sem_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .status      (status),
        .cmd         (cmd),
        .state       (state)
    );

    // The datapath holds the line buffers, window, counters and root unit.
    sem_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel        (pixel),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

`ifndef SYNTHESIS
    // New input is never taken while a word is in the root unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_ROOT) |-> !pixel_ready)
        else $error("pixel taken during root iteration");

    // A result only appears right after the final step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state) == ST_DONE)
        else $error("result raised outside the final step");

    // A dropped flush leaves the controller idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_ready && status.drop) |=> state == ST_IDLE)
        else $error("dropped flush started work");
`endif
endmodule
`default_nettype wire
